// ===== rtl/core/vlw_pkg.sv =====
// Shared types, constants and width helpers for the voxel line walker.
package vlw_pkg;

    // Default grid configuration.
    localparam int GRID_SIZE_DEF = 16;
    localparam int FRAC_BITS_DEF = 12;

    // Fixed transaction field widths.
    localparam int POS_IN_W   = 16;
    localparam int DIR_W      = 16;
    localparam int LEN_W      = 17;
    localparam int CELL_OUT_W = 4;

    // Direction components carry 14 fraction bits.
    localparam int DIR_FRAC = 14;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Default operand widths of the shared multiplier.
    localparam int POS_W_DEF     = $clog2(GRID_SIZE_DEF) + FRAC_BITS_DEF;
    localparam int MUL_A_W_DEF   = imax(LEN_W + 1, imax(POS_W_DEF + 1, FRAC_BITS_DEF + 2));
    localparam int MUL_B_W_DEF   = imax(DIR_W, 2 * POS_W_DEF + 1);

    // Operation codes carried in the op field.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    // Per-axis direction of travel.
    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    // Axis indexes and the code for no axis chosen.
    localparam int         AXIS_W    = 2;
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] PICK_NONE = 2'd3;

    typedef struct packed {
        logic                    op;
        logic [POS_IN_W-1:0]     start_x;
        logic [POS_IN_W-1:0]     start_y;
        logic [POS_IN_W-1:0]     start_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [LEN_W-1:0]        length;
        logic                    keep_going;
    } req_t;

    typedef struct packed {
        logic [CELL_OUT_W-1:0] cell_x;
        logic [CELL_OUT_W-1:0] cell_y;
        logic [CELL_OUT_W-1:0] cell_z;
        logic                  last_cell;
        logic                  cut_short;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DMUL,
        ST_POS,
        ST_OMUL,
        ST_OTH,
        ST_EMUL,
        ST_ERR,
        ST_FIRST,
        ST_PICK,
        ST_ADV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MS_DELTA,
        MS_OTHER,
        MS_ERROR
    } msel_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic  idle;
        logic  accept;
        logic  ld_pos;
        logic  ld_oth;
        logic  ld_err;
        logic  ld_first;
        logic  ld_pick;
        logic  ld_adv;
        logic  emit;
        msel_t msel;
    } ctl_t;

    // Status from the datapath and ports to the sequencer.
    typedef struct packed {
        logic req_valid;
        logic op;
        logic keep_going;
        logic walking;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/voxel_line_walker_3d_unit.sv =====
// Top level of the 3D voxel line walker: sequencer, shared multiplier and axis datapath.
//
// The request channel (req_valid, req_stall, req) carries one transaction per
// command. A start transaction (op = start) gives a start point, a direction and
// a length; the block answers with the cell that holds the start point. Each
// answer transaction (op = answer) reports whether the caller wants the walk to
// continue: with keep_going set the block steps one axis and returns the next
// cell, otherwise the walk ends and nothing is returned. Answers with no walk
// in progress are taken and dropped.
// On a start, the single shared multiplier is used nine times, three products per
// axis, each with an issue state (DMUL, OMUL, EMUL) and a load state (POS, OTH,
// ERR); then FIRST sets the cell flags and EMIT loads the output register, after
// which the block returns to idle for the next transaction. A continuing answer
// passes through PICK (compare the three crossing errors), ADV (advance) and
// EMIT (register the result); a stop answer is taken without leaving idle.
// req_stall is high whenever a command is being worked on.
// The response channel has its own output register, so a finished cell may wait
// under rsp_stall while the next command is already accepted; the block only
// waits when a second result is ready before the first has been taken.
// Reset clears the sequencer, the walk-active flag and rsp_valid.
module voxel_line_walker_3d_unit
    import vlw_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Cell index width and position width inside the grid.
    localparam int CELL_W = $clog2(GRID_SIZE);
    localparam int POS_W  = CELL_W + FRAC_BITS;
    // The running cell can wander past the grid edge by up to the step cap.
    localparam int CUR_W  = CELL_W + 3;
    localparam int V_W    = POS_W + 1;
    localparam int OTH_W  = 2 * POS_W + 1;
    localparam int DIF_W  = FRAC_BITS + 2;
    localparam int SUM_W  = imax(POS_W, 19) + 2;
    localparam int ERR_W  = imin(63, 3 * POS_W + 4);
    localparam int MA_W   = imax(LEN_W + 1, imax(V_W, DIF_W));
    localparam int MB_W   = imax(DIR_W, OTH_W);
    localparam int MP_W   = MA_W + MB_W;
    localparam int STEP_W = $clog2(3 * GRID_SIZE + 1);
    localparam int ONE    = 2 ** FRAC_BITS;
    localparam int RND    = (2 ** DIR_FRAC) - 1;

    localparam logic [POS_W-1:0]  POS_TOP  = POS_W'(GRID_SIZE * ONE - 1);
    localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(3 * GRID_SIZE);
    // Error sums saturate at plus or minus two to the 61st, which only fits
    // in the widest configurations; narrower errors can never reach it.
    localparam bit                    SAT_ON = (ERR_W >= 62);
    localparam logic signed [ERR_W:0] SAT_HI = SAT_ON ? (ERR_W + 1)'(64'sd1 <<< 61) : '0;
    localparam logic signed [ERR_W:0] SAT_LO = -SAT_HI;

    ctl_t  ctl;
    stat_t stat;

    // Per-axis state. During setup these arrays rotate by one entry per
    // axis, so the axis being worked on always sits in entry 0.
    logic [POS_IN_W-1:0]     st_reg   [3];
    logic signed [DIR_W-1:0] dir_reg  [3];
    logic [LEN_W-1:0]        len_reg;
    logic [POS_W-1:0]        p0_reg   [3];
    logic signed [V_W-1:0]   v_reg    [3];
    logic [CUR_W-1:0]        cur_reg  [3];
    logic [CELL_W-1:0]       end_reg  [3];
    logic [1:0]              sgn_reg  [3];
    logic signed [OTH_W-1:0] oth_reg  [3];
    logic signed [ERR_W-1:0] inc_reg  [3];
    logic signed [ERR_W-1:0] err_reg  [3];
    logic [STEP_W-1:0]       steps_reg;
    logic [AXIS_W-1:0]       pick_reg;
    logic                    last_reg;
    logic                    cut_reg;

    logic                    walking_reg;
    logic                    walking_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    rsp_t                    rsp_reg;

    // Shared multiplier.
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  prod;

    // Setup arithmetic for the axis in entry 0.
    logic [POS_W-1:0]        p0_new;
    logic [POS_W-1:0]        p1_new;
    logic signed [MP_W-1:0]  rnd;
    logic signed [MP_W-1:0]  dz_full;
    logic signed [SUM_W-1:0] dz;
    logic signed [SUM_W-1:0] p1_sum;
    logic [CELL_W-1:0]       cell0;
    logic [CELL_W-1:0]       cell1;
    logic [1:0]              sgn_new;
    logic signed [V_W-1:0]   v_new;
    logic signed [OTH_W-1:0] oth_new;
    logic signed [ERR_W-1:0] oth_sh;
    logic signed [ERR_W-1:0] inc_new;
    logic [CELL_W:0]         plane_cell;
    logic signed [POS_W+1:0] dif_w;
    logic signed [DIF_W-1:0] dif;
    logic signed [ERR_W-1:0] err_init;

    // Walk step arithmetic.
    logic [ERR_W-1:0]        mag      [3];
    logic                    mov      [3];
    logic [AXIS_W-1:0]       pick_new;
    logic [CUR_W-1:0]        cur_adv  [3];
    logic signed [ERR_W-1:0] err_sel;
    logic signed [ERR_W-1:0] inc_sel;
    logic signed [ERR_W:0]   err_sum;
    logic signed [ERR_W-1:0] err_new;
    logic [STEP_W-1:0]       steps_inc;
    logic                    hit_cur;
    logic                    hit_adv;
    logic                    cap_hit;

    vlw_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    vlw_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign stat.req_valid  = req_valid;
    assign stat.op         = req.op;
    assign stat.keep_going = req.keep_going;
    assign stat.walking    = walking_reg;
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

    assign req_stall = !ctl.idle;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = MA_W'($signed({1'b0, len_reg}));
        mul_b = MB_W'(dir_reg[0]);
        unique case (ctl.msel)
            MS_DELTA:
            begin
                mul_a = MA_W'($signed({1'b0, len_reg}));
                mul_b = MB_W'(dir_reg[0]);
            end
            MS_OTHER:
            begin
                mul_a = MA_W'(v_reg[1]);
                mul_b = MB_W'(v_reg[2]);
            end
            MS_ERROR:
            begin
                mul_a = MA_W'(dif);
                mul_b = MB_W'(oth_reg[0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Start and end positions of the axis in entry 0, clamped to the grid.
    always_comb
    begin
        if (SUM_W'(st_reg[0]) > SUM_W'(POS_TOP))
        begin
            p0_new = POS_TOP;
        end
        else
        begin
            p0_new = POS_W'(st_reg[0]);
        end

        // Direction times length, truncated towards zero.
        rnd     = prod[MP_W-1] ? MP_W'(RND) : '0;
        dz_full = (prod + rnd) >>> DIR_FRAC;
        dz      = SUM_W'(dz_full);
        p1_sum  = $signed(SUM_W'(p0_new)) + dz;

        if (p1_sum[SUM_W-1])
        begin
            p1_new = '0;
        end
        else if (p1_sum > $signed(SUM_W'(POS_TOP)))
        begin
            p1_new = POS_TOP;
        end
        else
        begin
            p1_new = p1_sum[POS_W-1:0];
        end

        cell0 = p0_new[POS_W-1:FRAC_BITS];
        cell1 = p1_new[POS_W-1:FRAC_BITS];

        if (cell1 > cell0)
        begin
            sgn_new = SGN_POS;
        end
        else if (cell1 < cell0)
        begin
            sgn_new = SGN_NEG;
        end
        else
        begin
            sgn_new = SGN_ZERO;
        end

        if (p1_new == p0_new)
        begin
            v_new = V_W'(ONE);
        end
        else
        begin
            v_new = $signed(V_W'(p1_new)) - $signed(V_W'(p0_new));
        end
    end

    // Product of the other two spans, the error increment and the first error.
    always_comb
    begin
        oth_new = OTH_W'(prod);
        oth_sh  = ERR_W'(oth_new) <<< FRAC_BITS;
        if (sgn_reg[0] == SGN_POS)
        begin
            inc_new = oth_sh;
        end
        else if (sgn_reg[0] == SGN_NEG)
        begin
            inc_new = -oth_sh;
        end
        else
        begin
            inc_new = '0;
        end

        plane_cell = (CELL_W + 1)'(cur_reg[0][CELL_W-1:0]) +
                     (CELL_W + 1)'(sgn_reg[0] == SGN_POS);
        dif_w      = $signed((POS_W + 2)'({plane_cell, FRAC_BITS'(0)})) -
                     $signed((POS_W + 2)'(p0_reg[0]));
        dif        = DIF_W'(dif_w);
        err_init   = ERR_W'(prod);
    end

    // Choose the moving axis with the smallest error magnitude; ties go to the later axis.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = err_reg[i][ERR_W-1] ? ERR_W'(-err_reg[i]) : ERR_W'(err_reg[i]);
            mov[i] = (sgn_reg[i] != SGN_ZERO);
        end

        priority if (mov[0] && (!mov[1] || (mag[0] < mag[1])) &&
                     (!mov[2] || (mag[0] < mag[2])))
        begin
            pick_new = AXIS_X;
        end
        else if (mov[1] && (!mov[2] || (mag[1] < mag[2])))
        begin
            pick_new = AXIS_Y;
        end
        else if (mov[2])
        begin
            pick_new = AXIS_Z;
        end
        else
        begin
            pick_new = PICK_NONE;
        end
    end

    // One step along the chosen axis.
    always_comb
    begin
        err_sel = err_reg[0];
        inc_sel = inc_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            cur_adv[i] = cur_reg[i];
        end

        unique case (pick_reg)
            AXIS_X, AXIS_Y, AXIS_Z:
            begin
                err_sel = err_reg[pick_reg];
                inc_sel = inc_reg[pick_reg];
                if (sgn_reg[pick_reg] == SGN_NEG)
                begin
                    cur_adv[pick_reg] = cur_reg[pick_reg] - CUR_W'(1);
                end
                else
                begin
                    cur_adv[pick_reg] = cur_reg[pick_reg] + CUR_W'(1);
                end
            end
            default:
            begin
                err_sel = err_reg[0];
            end
        endcase

        err_sum = (ERR_W + 1)'(err_sel) + (ERR_W + 1)'(inc_sel);
        if (SAT_ON && (err_sum > SAT_HI))
        begin
            err_new = ERR_W'(SAT_HI);
        end
        else if (SAT_ON && (err_sum < SAT_LO))
        begin
            err_new = ERR_W'(SAT_LO);
        end
        else
        begin
            err_new = ERR_W'(err_sum);
        end

        steps_inc = steps_reg + STEP_W'(1);
        cap_hit   = (steps_inc >= STEP_CAP);

        hit_cur = (cur_reg[0] == CUR_W'(end_reg[0])) &&
                  (cur_reg[1] == CUR_W'(end_reg[1])) &&
                  (cur_reg[2] == CUR_W'(end_reg[2]));
        hit_adv = (cur_adv[0] == CUR_W'(end_reg[0])) &&
                  (cur_adv[1] == CUR_W'(end_reg[1])) &&
                  (cur_adv[2] == CUR_W'(end_reg[2]));
    end

    // Segment inputs: loaded on a start transaction, rotated during setup.
    always_ff @(posedge clk)
    begin
        if (ctl.accept && (req.op == OP_START))
        begin
            st_reg[0]  <= req.start_x;
            st_reg[1]  <= req.start_y;
            st_reg[2]  <= req.start_z;
            dir_reg[0] <= req.dir_x;
            dir_reg[1] <= req.dir_y;
            dir_reg[2] <= req.dir_z;
            len_reg    <= req.length;
        end
        else if (ctl.ld_pos)
        begin
            st_reg[0]  <= st_reg[1];
            st_reg[1]  <= st_reg[2];
            st_reg[2]  <= st_reg[0];
            dir_reg[0] <= dir_reg[1];
            dir_reg[1] <= dir_reg[2];
            dir_reg[2] <= dir_reg[0];
        end
    end

    // Axis geometry, written in the position, other-product and error phases and carried round after.
    always_ff @(posedge clk)
    begin
        if (ctl.ld_pos || ctl.ld_oth || ctl.ld_err)
        begin
            p0_reg[0]  <= p0_reg[1];
            p0_reg[1]  <= p0_reg[2];
            p0_reg[2]  <= ctl.ld_pos ? p0_new : p0_reg[0];
            v_reg[0]   <= v_reg[1];
            v_reg[1]   <= v_reg[2];
            v_reg[2]   <= ctl.ld_pos ? v_new : v_reg[0];
            end_reg[0] <= end_reg[1];
            end_reg[1] <= end_reg[2];
            end_reg[2] <= ctl.ld_pos ? cell1 : end_reg[0];
            sgn_reg[0] <= sgn_reg[1];
            sgn_reg[1] <= sgn_reg[2];
            sgn_reg[2] <= ctl.ld_pos ? sgn_new : sgn_reg[0];
            cur_reg[0] <= cur_reg[1];
            cur_reg[1] <= cur_reg[2];
            cur_reg[2] <= ctl.ld_pos ? CUR_W'(cell0) : cur_reg[0];
            oth_reg[0] <= oth_reg[1];
            oth_reg[1] <= oth_reg[2];
            oth_reg[2] <= ctl.ld_oth ? oth_new : oth_reg[0];
            inc_reg[0] <= inc_reg[1];
            inc_reg[1] <= inc_reg[2];
            inc_reg[2] <= ctl.ld_oth ? inc_new : inc_reg[0];
            err_reg[0] <= err_reg[1];
            err_reg[1] <= err_reg[2];
            err_reg[2] <= ctl.ld_err ? err_init : err_reg[0];
        end
        else if (ctl.ld_adv && (pick_reg != PICK_NONE))
        begin
            cur_reg[pick_reg] <= cur_adv[pick_reg];
            err_reg[pick_reg] <= err_new;
        end
    end

    // Step count, chosen axis and the flags of the pending result.
    always_ff @(posedge clk)
    begin
        if (ctl.ld_pick)
        begin
            pick_reg <= pick_new;
        end

        if (ctl.ld_first)
        begin
            steps_reg <= '0;
            last_reg  <= hit_cur;
            cut_reg   <= 1'b0;
        end
        else if (ctl.ld_adv)
        begin
            steps_reg <= steps_inc;
            last_reg  <= hit_adv || cap_hit;
            cut_reg   <= cap_hit && !hit_adv;
        end
    end

    // Walk-active flag.
    always_comb
    begin
        walking_next = walking_reg;
        if (ctl.accept && (req.op == OP_ANSWER) && !req.keep_going)
        begin
            walking_next = 1'b0;
        end
        else if (ctl.ld_first)
        begin
            walking_next = !hit_cur;
        end
        else if (ctl.ld_adv && (hit_adv || cap_hit))
        begin
            walking_next = 1'b0;
        end
    end

    // Output register: holds a cell until the receiver takes it.
    always_comb
    begin
        if (ctl.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            walking_reg   <= walking_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rsp_reg.cell_x    <= cur_reg[AXIS_X][CELL_OUT_W-1:0];
            rsp_reg.cell_y    <= cur_reg[AXIS_Y][CELL_OUT_W-1:0];
            rsp_reg.cell_z    <= cur_reg[AXIS_Z][CELL_OUT_W-1:0];
            rsp_reg.last_cell <= last_reg;
            rsp_reg.cut_short <= cut_reg;
        end
    end

endmodule

// ===== rtl/core/vlw_mul.sv =====
// Shared signed multiplier with a registered product.
module vlw_mul
    import vlw_pkg::*;
#(
    parameter int A_W = MUL_A_W_DEF,
    parameter int B_W = MUL_B_W_DEF
)
(
    input  logic                       clk,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic signed [A_W+B_W-1:0]  prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/vlw_ctrl.sv =====
// Sequencer that steps the shared multiplier through setup and the walk.
module vlw_ctrl
    import vlw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t              state_reg;
    state_t              state_next;
    logic [AXIS_W-1:0]   ax_reg;
    logic [AXIS_W-1:0]   ax_next;
    logic                ax_step;
    logic                ax_last;

    assign ax_last = (ax_reg == AXIS_Z);
    assign ax_step = (state_reg == ST_POS) || (state_reg == ST_OTH) || (state_reg == ST_ERR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ax_reg    <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
        end
    end

    always_comb
    begin
        ax_next = ax_reg;
        if (ax_step)
        begin
            ax_next = ax_last ? AXIS_X : ax_reg + AXIS_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.req_valid)
                begin
                    if (stat.op == OP_START)
                    begin
                        state_next = ST_DMUL;
                    end
                    else if (stat.walking && stat.keep_going)
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_DMUL:  state_next = ST_POS;
            ST_POS:   state_next = ax_last ? ST_OMUL : ST_DMUL;
            ST_OMUL:  state_next = ST_OTH;
            ST_OTH:   state_next = ax_last ? ST_EMUL : ST_OMUL;
            ST_EMUL:  state_next = ST_ERR;
            ST_ERR:   state_next = ax_last ? ST_FIRST : ST_EMUL;
            ST_FIRST: state_next = ST_EMIT;
            ST_PICK:  state_next = ST_ADV;
            ST_ADV:   state_next = ST_EMIT;
            ST_EMIT:  state_next = stat.out_free ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        ctl.msel     = MS_DELTA;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.idle   = 1'b1;
                ctl.accept = stat.req_valid;
            end
            ST_DMUL:  ctl.msel = MS_DELTA;
            ST_POS:   ctl.ld_pos = 1'b1;
            ST_OMUL:  ctl.msel = MS_OTHER;
            ST_OTH:   ctl.ld_oth = 1'b1;
            ST_EMUL:  ctl.msel = MS_ERROR;
            ST_ERR:   ctl.ld_err = 1'b1;
            ST_FIRST: ctl.ld_first = 1'b1;
            ST_PICK:  ctl.ld_pick = 1'b1;
            ST_ADV:   ctl.ld_adv = 1'b1;
            ST_EMIT:  ctl.emit = stat.out_free;
            default:  ctl.idle = 1'b0;
        endcase
    end

endmodule

// ===== tb/sv/tb_vlw_scoreboard_pkg.sv =====
// Scoreboard class for the voxel line walker: integer walk predictor and queue of cells due.
`timescale 1ns / 1ps

package tb_vlw_scoreboard_pkg;
    import vlw_pkg::*;

    localparam longint ONE_CELL = longint'(1) << FRAC_BITS_DEF;
    localparam longint GRID_TOP = (longint'(GRID_SIZE_DEF) << FRAC_BITS_DEF) - 1;
    localparam longint ERR_CEIL = longint'(1) << 61;
    localparam int     STEP_CAP = 3 * GRID_SIZE_DEF;

    class walk_scoreboard;
        bit     walking;
        longint cell_now[3];
        longint cell_end[3];
        longint heading[3];
        longint cross_err[3];
        longint cross_inc[3];
        int     step_count;
        rsp_t   cells_due[$];
        int     bad_count;

        function longint onto_grid(longint p);
            if (p < 0)
                return 0;
            if (p > GRID_TOP)
                return GRID_TOP;
            return p;
        endfunction

        function bit reached_end();
            return cell_now[AXIS_X] == cell_end[AXIS_X] &&
                   cell_now[AXIS_Y] == cell_end[AXIS_Y] &&
                   cell_now[AXIS_Z] == cell_end[AXIS_Z];
        endfunction

        function void queue_cell(bit last, bit cut);
            rsp_t c;
            c.cell_x    = CELL_OUT_W'(cell_now[AXIS_X]);
            c.cell_y    = CELL_OUT_W'(cell_now[AXIS_Y]);
            c.cell_z    = CELL_OUT_W'(cell_now[AXIS_Z]);
            c.last_cell = last;
            c.cut_short = cut;
            cells_due.push_back(c);
        endfunction

        // Updates the walk state for one accepted request and queues the cell it produces, if any.
        function void note_request(req_t r);
            longint     p0[3];
            longint     p1[3];
            longint     span[3];
            longint     dirv[3];
            longint     len;
            longint     prod;
            longint     delta;
            longint     other;
            longint     plane;
            longint     mag_err[3];
            longint     sum;
            logic [1:0] pick;
            bit         done;
            bit         capped;
            int         a;

            if (r.op == OP_START)
            begin
                p0[AXIS_X]   = longint'(r.start_x);
                p0[AXIS_Y]   = longint'(r.start_y);
                p0[AXIS_Z]   = longint'(r.start_z);
                dirv[AXIS_X] = longint'($signed(r.dir_x));
                dirv[AXIS_Y] = longint'($signed(r.dir_y));
                dirv[AXIS_Z] = longint'($signed(r.dir_z));
                len          = longint'(r.length);
                for (a = 0; a < 3; a++)
                begin
                    // The product is truncated towards zero, not floored.
                    prod  = dirv[a] * len;
                    delta = (prod < 0) ? -((-prod) >>> DIR_FRAC) : (prod >>> DIR_FRAC);
                    p0[a] = onto_grid(p0[a]);
                    p1[a] = onto_grid(p0[a] + delta);
                    cell_now[a] = p0[a] >>> FRAC_BITS_DEF;
                    cell_end[a] = p1[a] >>> FRAC_BITS_DEF;
                    heading[a]  = (cell_end[a] > cell_now[a]) ? 1 :
                                  (cell_end[a] < cell_now[a]) ? -1 : 0;
                    span[a]     = (p1[a] == p0[a]) ? ONE_CELL : (p1[a] - p0[a]);
                end
                for (a = 0; a < 3; a++)
                begin
                    other = span[(a + 1) % 3] * span[(a + 2) % 3];
                    plane = (cell_now[a] + ((heading[a] > 0) ? 1 : 0)) << FRAC_BITS_DEF;
                    cross_err[a] = (plane - p0[a]) * other;
                    cross_inc[a] = heading[a] * (other * ONE_CELL);
                end
                step_count = 0;
                done       = reached_end();
                walking    = !done;
                queue_cell(done, 1'b0);
            end
            else if (walking)
            begin
                if (!r.keep_going)
                begin
                    walking = 1'b0;
                end
                else
                begin
                    for (a = 0; a < 3; a++)
                        mag_err[a] = (cross_err[a] < 0) ? -cross_err[a] : cross_err[a];
                    // Ties go to the later axis: x must be strictly nearest, y strictly below z.
                    pick = PICK_NONE;
                    if (heading[AXIS_X] != 0 &&
                        (heading[AXIS_Y] == 0 || mag_err[AXIS_X] < mag_err[AXIS_Y]) &&
                        (heading[AXIS_Z] == 0 || mag_err[AXIS_X] < mag_err[AXIS_Z]))
                        pick = AXIS_X;
                    else if (heading[AXIS_Y] != 0 &&
                             (heading[AXIS_Z] == 0 || mag_err[AXIS_Y] < mag_err[AXIS_Z]))
                        pick = AXIS_Y;
                    else if (heading[AXIS_Z] != 0)
                        pick = AXIS_Z;
                    if (pick != PICK_NONE)
                    begin
                        cell_now[pick] = cell_now[pick] + heading[pick];
                        sum = cross_err[pick] + cross_inc[pick];
                        if (sum > ERR_CEIL)
                            sum = ERR_CEIL;
                        else if (sum < -ERR_CEIL)
                            sum = -ERR_CEIL;
                        cross_err[pick] = sum;
                    end
                    step_count++;
                    done   = reached_end();
                    capped = step_count >= STEP_CAP;
                    if (done || capped)
                        walking = 1'b0;
                    queue_cell(done || capped, capped && !done);
                end
            end
        endfunction

        // Compares one accepted cell with the oldest one due.
        function void check_cell(rsp_t got);
            rsp_t want;
            if (cells_due.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: cell %0d,%0d,%0d last=%0b cut=%0b arrived with none due",
                             $time, got.cell_x, got.cell_y, got.cell_z,
                             got.last_cell, got.cut_short);
                return;
            end
            want = cells_due.pop_front();
            if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
                got.cell_z !== want.cell_z || got.last_cell !== want.last_cell ||
                got.cut_short !== want.cut_short)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: cell mismatch, expected %0d,%0d,%0d last=%0b cut=%0b, got %0d,%0d,%0d last=%0b cut=%0b",
                             $time, want.cell_x, want.cell_y, want.cell_z,
                             want.last_cell, want.cut_short, got.cell_x, got.cell_y,
                             got.cell_z, got.last_cell, got.cut_short);
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_voxel_line_walker_3d_unit.sv =====
// Testbench top for the 3D voxel line walker: stimulus, idling, response checking and run end.
`timescale 1ns / 1ps

module tb_voxel_line_walker_3d_unit;
    import vlw_pkg::*;
    import tb_vlw_scoreboard_pkg::*;

    // Transactions that do real work (starts and answers during a walk) before the run ends.
    localparam int ITEM_GOAL    = 1850;
    // Towards the end both sides stop idling so that back-to-back traffic is also seen.
    localparam int CALM_FROM    = 1650;
    // The drain wait allows comfortably more than a start needs.
    localparam int DRAIN_CYCLES = 40;
    // The watchdog allows several times the slowest legal run.
    localparam int CYCLE_LIMIT  = 600000;

    localparam int HALF_CELL = 1 << (FRAC_BITS_DEF - 1);
    localparam int FULL_CELL = 1 << FRAC_BITS_DEF;
    localparam int DIR_ONE   = 1 << DIR_FRAC;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    walk_scoreboard sb;
    int             live_items = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             calm = 1'b0;

    voxel_line_walker_3d_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Every field random over its full width, so that each bit is seen at both values,
    // including the fields that the current operation does not use.
    function automatic req_t scramble();
        req_t r;
        r.op         = 1'($urandom_range(0, 1));
        r.start_x    = POS_IN_W'($urandom_range(0, 65535));
        r.start_y    = POS_IN_W'($urandom_range(0, 65535));
        r.start_z    = POS_IN_W'($urandom_range(0, 65535));
        r.dir_x      = DIR_W'($urandom_range(0, 65535));
        r.dir_y      = DIR_W'($urandom_range(0, 65535));
        r.dir_z      = DIR_W'($urandom_range(0, 65535));
        r.length     = LEN_W'($urandom_range(0, 131071));
        r.keep_going = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic req_t make_start(input int sx, sy, sz, dx, dy, dz, len);
        req_t r;
        r         = scramble();
        r.op      = OP_START;
        r.start_x = POS_IN_W'(sx);
        r.start_y = POS_IN_W'(sy);
        r.start_z = POS_IN_W'(sz);
        r.dir_x   = DIR_W'(dx);
        r.dir_y   = DIR_W'(dy);
        r.dir_z   = DIR_W'(dz);
        r.length  = LEN_W'(len);
        return r;
    endfunction

    function automatic req_t answer(input bit keep);
        req_t r;
        r            = scramble();
        r.op         = OP_ANSWER;
        r.keep_going = keep;
        return r;
    endfunction

    // A direction component within the unit range.
    function automatic logic signed [DIR_W-1:0] unit_dir();
        int k;
        k = $urandom_range(0, 2 * DIR_ONE);
        return DIR_W'(k - DIR_ONE);
    endfunction

    // A step of a whole number of half cells, given a length of exactly 4.0.
    function automatic logic signed [DIR_W-1:0] half_cell_dir();
        int k;
        k = $urandom_range(0, 16);
        return DIR_W'((k - 8) * HALF_CELL);
    endfunction

    // Start transactions come in three flavours. Fully random ones include directions
    // outside the unit range. Half-cell aligned ones put starts and ends on cell
    // boundaries and centres, which is where the crossing errors tie and the walk can
    // run past its end cell into the step cap. The rest are ordinary unit directions.
    function automatic req_t random_start();
        req_t r;
        int   roll;
        r    = scramble();
        r.op = OP_START;
        roll = $urandom_range(0, 9);
        if (roll >= 1 && roll <= 3)
        begin
            r.start_x = POS_IN_W'($urandom_range(0, 31) * HALF_CELL);
            r.start_y = POS_IN_W'($urandom_range(0, 31) * HALF_CELL);
            r.start_z = POS_IN_W'($urandom_range(0, 31) * HALF_CELL);
            r.dir_x   = half_cell_dir();
            r.dir_y   = half_cell_dir();
            r.dir_z   = half_cell_dir();
            r.length  = LEN_W'(4 * FULL_CELL);
        end
        else if (roll > 3)
        begin
            r.dir_x = unit_dir();
            r.dir_y = unit_dir();
            r.dir_z = unit_dir();
        end
        return r;
    endfunction

    // Presents one request transaction, with an occasional idle burst in front of it,
    // and holds it until the block takes it. The predictor is told at the edge of
    // acceptance, so that the next choice can follow whether a walk is still active.
    task automatic send_request(input req_t item);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        if (item.op == OP_START || sb.walking)
            live_items++;
        sb.note_request(item);
        if (live_items >= CALM_FROM)
            calm = 1'b1;
    endtask

    // A well-formed walk: a start, then continuing answers for as long as the walk is
    // active. Now and then the caller stops early, or drops the walk for a new start,
    // and now and then a stray answer follows the end of the walk.
    task automatic walk_once();
        int roll;
        send_request(random_start());
        while (sb.walking)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                break;
            send_request(answer(roll >= 8));
        end
        if ($urandom_range(0, 9) == 0)
            send_request(answer(1'($urandom_range(0, 1))));
    endtask

    // Response side: check every accepted transaction, then decide the stall for the
    // next cycle. Stall bursts have a random length and cease in the calm phase.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_cell(rsp);
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (rst_n && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 11);
        end
    end

    // Watchdog: a run that has not finished by now is hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_voxel_line_walker_3d_unit: FAIL");
        $finish;
    end

    initial
    begin
        sb = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An answer with no walk active is taken and dropped.
        send_request(answer(1'b1));
        // Start already at its end: origin with no movement.
        send_request(make_start(0, 0, 0, 0, 0, 0, 0));
        // Far corner pushed further out: the end clamps back onto the grid.
        send_request(make_start(65535, 65535, 65535,
                                DIR_ONE, DIR_ONE, DIR_ONE, 131071));
        // Origin pushed below zero: the end clamps to zero.
        send_request(make_start(0, 0, 0, -DIR_ONE, -DIR_ONE, -DIR_ONE, 131071));
        // Two cells down the x axis from a cell centre, then a stray answer after the end.
        send_request(make_start(8 * FULL_CELL + HALF_CELL, 8 * FULL_CELL + HALF_CELL,
                                8 * FULL_CELL + HALF_CELL, -DIR_ONE, 0, 0, 2 * FULL_CELL));
        send_request(answer(1'b1));
        send_request(answer(1'b1));
        send_request(answer(1'b1));
        // A diagonal walk stopped by the caller, then an answer that is ignored.
        send_request(make_start(3 * HALF_CELL, 3 * HALF_CELL, 3 * HALF_CELL,
                                9459, 9459, 9459, 4 * FULL_CELL));
        send_request(answer(1'b1));
        send_request(answer(1'b0));
        send_request(answer(1'b1));
        // Directions outside the unit range, used as given; then a new start replaces
        // the walk in progress.
        send_request(make_start('h1234, 'hABCD, 'h8000,
                                -32768, 32767, -1, 131071));
        send_request(answer(1'b1));
        send_request(make_start(4 * FULL_CELL, 4 * FULL_CELL, 4 * FULL_CELL,
                                0, DIR_ONE, 0, 3 * FULL_CELL));
        send_request(answer(1'b1));
        // Step cap: x's final crossing and an extra z crossing both fall at the very
        // end of the segment. The tie sends z past its end cell, the end cell is never
        // reached, and the walk runs until the cap cuts it short.
        send_request(make_start(HALF_CELL, 5 * FULL_CELL + HALF_CELL,
                                3 * FULL_CELL + HALF_CELL,
                                6144, 0, -10240, 4 * FULL_CELL));
        repeat (STEP_CAP) send_request(answer(1'b1));

        // Random part: mostly well-formed walks, the rest noise.
        while (live_items < ITEM_GOAL)
        begin
            if ($urandom_range(0, 9) < 8)
                walk_once();
            else
                send_request(scramble());
        end
        req_valid <= 1'b0;

        while (sb.cells_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.bad_count == 0 && sb.cells_due.size() == 0)
            $display("tb_voxel_line_walker_3d_unit: PASS");
        else
            $display("tb_voxel_line_walker_3d_unit: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vlw_pkg.sv
rtl/core/vlw_mul.sv
rtl/core/vlw_ctrl.sv
rtl/core/voxel_line_walker_3d_unit.sv
tb/sv/tb_vlw_scoreboard_pkg.sv
tb/sv/tb_voxel_line_walker_3d_unit.sv
